@@ hw/rtl/heightmap_vertex_normals_unit_defines.svh @@
// assertion macros for the heightmap vertex normals unit
// used by the top level only; empty bodies when SYNTHESIS is defined
`ifndef HEIGHTMAP_VERTEX_NORMALS_UNIT_DEFINES_SVH
`define HEIGHTMAP_VERTEX_NORMALS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HVN_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hvn check failed");
`define HVN_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hvn check failed");
`else
`define HVN_ASSERT_IMP(name, ante, cons)
`define HVN_ASSERT_NXT(name, ante, cons)
`endif
`endif

@@ hw/rtl/hvn_pkg.sv @@
// types, constants and helpers of the heightmap vertex normals unit
// no dependencies
package hvn_pkg;

    localparam int SUM_W    = 11;
    localparam int SY_W     = 6;
    localparam int MAG_W    = 10;
    localparam int LEN2_W   = 22;
    localparam int MSQ_W    = 2 * MAG_W;
    localparam int ACC_W    = 56;
    localparam int Z_W      = 40;
    localparam int F_W      = 17;
    localparam int BIT_W    = 5;
    localparam int COORD_W  = 10;
    localparam int FACE_UP  = 15;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int TDATA_W  = 72;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic [SY_W-1:0]         sy;
        logic signed [SUM_W-1:0] sz;
    } sum_t;

    typedef struct packed {
        sum_t               s;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               fend;
    } res_t;

    typedef struct packed {
        logic [1:0]      n;
        res_t [2:0]      res;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {F_IDLE, F_READ, F_SUM, F_PUSH} front_state_t;
    typedef enum logic [1:0] {B_IDLE, B_SETUP, B_ITER, B_OUT} back_state_t;

    function automatic sum_t add_face(sum_t s, logic [7:0] a, logic [7:0] b,
                                      logic [7:0] d, logic en);
        sum_t r;
        r = s;
        if (en) begin
            r.sx = r.sx + SUM_W'(a) - SUM_W'(b);
            r.sy = r.sy + SY_W'(FACE_UP);
            r.sz = r.sz + SUM_W'(a) - SUM_W'(d);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/heightmap_vertex_normals_unit.sv @@
// Smooth vertex normals of a streamed heightmap. Height bytes enter on the
// s_ channel in raster order; unit normals leave on the m_ channel as Q1.15
// with the vertex column and row. The cfg channel writes grid_width (index 0)
// and grid_height (index 1), each clamped to 2..MAX; write them only when idle.
// A sample at row r emits the normal of the vertex above it (r >= 1); samples
// of the last row also emit the vertex to their left, and the final sample of
// the frame adds the last vertex with m_tuser set. m_tlast marks the final
// normal caused by one sample. Row 0 samples emit nothing.
// The front end handles a sample in intake, four line-store reads, capture
// and queue push, and takes the next sample only after the push. Each normal
// passes the back end in setup, 17 steps of the bit-serial root search and
// output load; a job is taken from the queue in the idle state. A last-row
// sample can carry three normals.
// A two-entry queue lets the front keep taking samples while the back end
// works, and the output register holds a result while m_tready is low.
// Synchronous reset clears counters and handshakes; line stores hold garbage
// until written and need no clearing pass.
`include "heightmap_vertex_normals_unit_defines.svh"
module heightmap_vertex_normals_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // height_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // normal_x, normal_y, normal_z, vertex_col, vertex_row
    output logic [hvn_pkg::TDATA_W-1:0]        m_tdata,
    output logic                               m_tlast,   // last_of_run
    output logic                               m_tuser,   // frame_end
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hvn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hvn_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [hvn_pkg::CFG_DATA_W-1:0] grid_width_reg, grid_height_reg;
    hvn_pkg::q_stat_t q_stat;
    hvn_pkg::job_t    push_job, pop_job;
    logic             q_push, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= hvn_pkg::CFG_DATA_W'(256);
            grid_height_reg <= hvn_pkg::CFG_DATA_W'(256);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                hvn_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                hvn_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    hvn_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    hvn_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .job_in  (push_job),
        .pop     (q_pop),
        .job_out (pop_job),
        .stat    (q_stat)
    );

    hvn_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `HVN_ASSERT_IMP(a_push_not_full, q_push, !q_stat.full)
    `HVN_ASSERT_IMP(a_pop_not_empty, q_pop, !q_stat.empty)
    `HVN_ASSERT_NXT(a_push_fills, q_push, !q_stat.empty)
    `HVN_ASSERT_IMP(a_frame_end_last, m_tvalid && m_tuser, m_tlast)

endmodule

@@ hw/rtl/hvn_front.sv @@
// front end: sample intake, grid counters, three rotating line stores,
// face sums of the vertices each sample completes; uses hvn_pkg
module hvn_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  logic [hvn_pkg::CFG_DATA_W-1:0]      grid_width,
    input  logic [hvn_pkg::CFG_DATA_W-1:0]      grid_height,
    input  hvn_pkg::q_stat_t                    q_stat,
    output logic                                q_push,
    output hvn_pkg::job_t                       q_job
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int MW = (WW > HW) ? WW : HW;
    localparam int CMPW = (MW > hvn_pkg::CFG_DATA_W) ? MW : hvn_pkg::CFG_DATA_W;
    localparam int AW2 = CW + 2;

    typedef struct packed {
        logic emit_a;
        logic last_row;
        logic last_col;
        logic c_ge1;
        logic c_ge2;
        logic r_ge2;
    } cls_t;

    hvn_pkg::front_state_t state_reg, state_next;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [1:0]    base_reg;
    logic [CW-1:0] c_reg;
    logic [RW-1:0] r_reg;
    logic [1:0]    base_item_reg;
    cls_t          cls_reg;
    logic [1:0]    k_reg;
    logic          cap_vld_reg;
    logic [1:0]    cap_k_reg;
    logic [7:0]    bank_rd_reg [3];
    logic [7:0]    win_t_reg [4];
    logic [7:0]    win_p_reg [4];
    logic [7:0]    win_u_reg [4];

    logic [CMPW-1:0] wv, hv;
    logic [WW-1:0]   w_eff, w_last;
    logic [HW-1:0]   h_eff, h_last;
    logic [CW-1:0]   c_now;
    logic [RW-1:0]   r_now;
    logic            last_col_now, last_row_now, acc;
    logic [CW-1:0]   rd_addr;
    logic [1:0]      idx_t, idx_p;
    logic            emit_b, emit_c;
    logic [1:0]      n_res;
    hvn_pkg::sum_t   sa, sb, sc;

    always_comb begin
        wv = CMPW'(grid_width);
        hv = CMPW'(grid_height);
        w_eff = (wv < CMPW'(2)) ? WW'(2) :
                (wv > CMPW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wv);
        h_eff = (hv < CMPW'(2)) ? HW'(2) :
                (hv > CMPW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(hv);
        w_last = w_eff - WW'(1);
        h_last = h_eff - HW'(1);
        c_now = (WW'(col_reg) > w_last) ? CW'(w_last) : col_reg;
        r_now = (HW'(row_reg) > h_last) ? RW'(h_last) : row_reg;
        last_col_now = (WW'(c_now) == w_last);
        last_row_now = (HW'(r_now) == h_last);
    end

    assign acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end else if (acc) begin
            if (last_col_now) begin
                col_reg  <= '0;
                row_reg  <= last_row_now ? '0 : r_now + RW'(1);
                base_reg <= (base_reg == 2'd2) ? 2'd0 : base_reg + 2'd1;
            end else begin
                col_reg <= c_now + CW'(1);
                row_reg <= r_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            c_reg           <= c_now;
            r_reg           <= r_now;
            base_item_reg   <= base_reg;
            cls_reg.emit_a  <= (r_now != '0);
            cls_reg.last_row <= last_row_now;
            cls_reg.last_col <= last_col_now;
            cls_reg.c_ge1   <= (c_now != '0);
            cls_reg.c_ge2   <= (WW'(c_now) >= WW'(2));
            cls_reg.r_ge2   <= (HW'(r_now) >= HW'(2));
        end
    end

    // line stores, rotated by the base pointer at each row end
    assign rd_addr = CW'(AW2'(c_reg) + AW2'(k_reg) - AW2'(2));

    for (genvar g = 0; g < 3; g++) begin : g_bank
        logic [7:0] mem [MAX_WIDTH];
        always_ff @(posedge aclk) begin
            if (acc && (base_reg == 2'(g))) begin
                mem[c_now] <= s_tdata;
            end
            bank_rd_reg[g] <= mem[rd_addr];
        end
    end

    assign idx_t = (base_item_reg == 2'd0) ? 2'd1 :
                   (base_item_reg == 2'd1) ? 2'd2 : 2'd0;
    assign idx_p = (base_item_reg == 2'd0) ? 2'd2 : base_item_reg - 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_vld_reg <= 1'b0;
        end else begin
            cap_vld_reg <= (state_reg == hvn_pkg::F_READ);
        end
        cap_k_reg <= k_reg;
        if (cap_vld_reg) begin
            win_t_reg[cap_k_reg] <= bank_rd_reg[idx_t];
            win_p_reg[cap_k_reg] <= bank_rd_reg[idx_p];
            win_u_reg[cap_k_reg] <= bank_rd_reg[base_item_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hvn_pkg::F_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == hvn_pkg::F_READ) begin
                k_reg <= k_reg + 2'd1;
            end else begin
                k_reg <= '0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hvn_pkg::F_IDLE: if (acc) state_next = hvn_pkg::F_READ;
            hvn_pkg::F_READ: if (k_reg == 2'd3) state_next = hvn_pkg::F_SUM;
            hvn_pkg::F_SUM:  state_next = hvn_pkg::F_PUSH;
            hvn_pkg::F_PUSH: if (n_res == '0 || !q_stat.full) state_next = hvn_pkg::F_IDLE;
            default:         state_next = hvn_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        q_push   = 1'b0;
        unique case (state_reg)
            hvn_pkg::F_IDLE: s_tready = 1'b1;
            hvn_pkg::F_PUSH: q_push = (n_res != '0) && !q_stat.full;
            default: ;
        endcase
    end

    // window columns c-2 .. c+1 at indexes 0 .. 3
    always_comb begin
        emit_b = cls_reg.last_row && cls_reg.c_ge1;
        emit_c = cls_reg.last_row && cls_reg.last_col;
        n_res = cls_reg.emit_a ? (2'd1 + 2'(emit_b) + 2'(emit_c)) : 2'd0;

        sa = '0;
        sa = hvn_pkg::add_face(sa, win_t_reg[1], win_t_reg[2], win_p_reg[1],
                               cls_reg.c_ge1 && cls_reg.r_ge2);
        sa = hvn_pkg::add_face(sa, win_t_reg[2], win_t_reg[3], win_p_reg[2],
                               !cls_reg.last_col && cls_reg.r_ge2);
        sa = hvn_pkg::add_face(sa, win_p_reg[1], win_p_reg[2], win_u_reg[1],
                               cls_reg.c_ge1);
        sa = hvn_pkg::add_face(sa, win_p_reg[2], win_p_reg[3], win_u_reg[2],
                               !cls_reg.last_col);

        sb = '0;
        sb = hvn_pkg::add_face(sb, win_p_reg[0], win_p_reg[1], win_u_reg[0],
                               cls_reg.c_ge2);
        sb = hvn_pkg::add_face(sb, win_p_reg[1], win_p_reg[2], win_u_reg[1], 1'b1);

        sc = '0;
        sc = hvn_pkg::add_face(sc, win_p_reg[1], win_p_reg[2], win_u_reg[1], 1'b1);

        q_job = '0;
        q_job.n = n_res;
        q_job.res[0].s    = sa;
        q_job.res[0].col  = hvn_pkg::COORD_W'(c_reg);
        q_job.res[0].row  = hvn_pkg::COORD_W'(r_reg - RW'(1));
        q_job.res[0].fend = 1'b0;
        q_job.res[1].s    = sb;
        q_job.res[1].col  = hvn_pkg::COORD_W'(c_reg - CW'(1));
        q_job.res[1].row  = hvn_pkg::COORD_W'(r_reg);
        q_job.res[1].fend = 1'b0;
        q_job.res[2].s    = sc;
        q_job.res[2].col  = hvn_pkg::COORD_W'(c_reg);
        q_job.res[2].row  = hvn_pkg::COORD_W'(r_reg);
        q_job.res[2].fend = 1'b1;
    end

endmodule

@@ hw/rtl/hvn_queue.sv @@
// two-entry job queue between front and back end
// uses hvn_pkg
module hvn_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  hvn_pkg::job_t    job_in,
    input  logic             pop,
    output hvn_pkg::job_t    job_out,
    output hvn_pkg::q_stat_t stat
);

    hvn_pkg::job_t                ent_reg [hvn_pkg::QDEPTH];
    logic [hvn_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [hvn_pkg::QPTR_W:0]     count_reg;

    assign job_out    = ent_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (hvn_pkg::QPTR_W + 1)'(hvn_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + hvn_pkg::QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + hvn_pkg::QPTR_W'(1);
            if (push && !pop) begin
                count_reg <= count_reg + (hvn_pkg::QPTR_W + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (hvn_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

@@ hw/rtl/hvn_back.sv @@
// back end: per-vertex normalization by a bit-serial root search in three
// component lanes, rounding, saturation and the output register; uses hvn_pkg
module hvn_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hvn_pkg::q_stat_t             q_stat,
    input  hvn_pkg::job_t                q_job,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [hvn_pkg::TDATA_W-1:0]  m_tdata,  // normal_x, normal_y, normal_z, vertex_col, vertex_row
    output logic                         m_tlast,  // last_of_run
    output logic                         m_tuser   // frame_end
);

    localparam int MW = hvn_pkg::MAG_W;

    hvn_pkg::back_state_t state_reg, state_next;

    hvn_pkg::job_t             job_reg;
    logic [1:0]                slot_reg;
    logic [hvn_pkg::LEN2_W-1:0] len2_reg;
    logic [hvn_pkg::MSQ_W-1:0] msq_reg [3];
    logic [hvn_pkg::ACC_W-1:0] y_reg [3];
    logic [hvn_pkg::Z_W-1:0]   z_reg [3];
    logic [hvn_pkg::F_W-1:0]   f_reg [3];
    logic                      neg_x_reg, neg_z_reg;
    logic [hvn_pkg::BIT_W-1:0] bit_reg;
    logic                      m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [hvn_pkg::TDATA_W-1:0] m_tdata_reg;

    hvn_pkg::res_t             cur;
    logic [MW-1:0]             mag [3];
    logic [hvn_pkg::ACC_W-1:0] y_try [3];
    logic                      take [3];
    logic [hvn_pkg::F_W:0]     q_rnd [3];
    logic [14:0]               q_sat [3];
    logic [15:0]               nx, nz;
    logic                      out_free;

    assign cur = job_reg.res[slot_reg];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        mag[0] = cur.s.sx[hvn_pkg::SUM_W-1] ? MW'(-cur.s.sx) : MW'(cur.s.sx);
        mag[1] = MW'(cur.s.sy);
        mag[2] = cur.s.sz[hvn_pkg::SUM_W-1] ? MW'(-cur.s.sz) : MW'(cur.s.sz);
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        always_comb begin
            y_try[l] = y_reg[l]
                     + (hvn_pkg::ACC_W'(z_reg[l]) << (bit_reg + 1))
                     + (hvn_pkg::ACC_W'(len2_reg) << (2 * bit_reg));
            take[l]  = (y_try[l] <= hvn_pkg::ACC_W'({msq_reg[l], 32'b0}));
            q_rnd[l] = ((hvn_pkg::F_W + 1)'(f_reg[l]) + (hvn_pkg::F_W + 1)'(1)) >> 1;
            q_sat[l] = (q_rnd[l] > (hvn_pkg::F_W + 1)'(32767)) ? 15'h7FFF : q_rnd[l][14:0];
        end

        always_ff @(posedge aclk) begin
            if (state_reg == hvn_pkg::B_SETUP) begin
                msq_reg[l] <= hvn_pkg::MSQ_W'(mag[l]) * hvn_pkg::MSQ_W'(mag[l]);
                y_reg[l]   <= '0;
                z_reg[l]   <= '0;
                f_reg[l]   <= '0;
            end else if (state_reg == hvn_pkg::B_ITER && take[l]) begin
                y_reg[l] <= y_try[l];
                z_reg[l] <= z_reg[l] + (hvn_pkg::Z_W'(len2_reg) << bit_reg);
                f_reg[l] <= f_reg[l] | (hvn_pkg::F_W'(1) << bit_reg);
            end
        end
    end

    assign nx = neg_x_reg ? -{1'b0, q_sat[0]} : {1'b0, q_sat[0]};
    assign nz = neg_z_reg ? -{1'b0, q_sat[2]} : {1'b0, q_sat[2]};

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
        if (state_reg == hvn_pkg::B_SETUP) begin
            len2_reg  <= hvn_pkg::LEN2_W'(mag[0]) * hvn_pkg::LEN2_W'(mag[0])
                       + hvn_pkg::LEN2_W'(mag[1]) * hvn_pkg::LEN2_W'(mag[1])
                       + hvn_pkg::LEN2_W'(mag[2]) * hvn_pkg::LEN2_W'(mag[2]);
            neg_x_reg <= cur.s.sx[hvn_pkg::SUM_W-1];
            neg_z_reg <= cur.s.sz[hvn_pkg::SUM_W-1];
        end
        if (state_reg == hvn_pkg::B_OUT && out_free) begin
            m_tdata_reg <= {5'b0, cur.row, cur.col, nz, q_sat[1], nx};
            m_tlast_reg <= (slot_reg == job_reg.n - 2'd1);
            m_tuser_reg <= cur.fend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hvn_pkg::B_IDLE;
            slot_reg     <= '0;
            bit_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                slot_reg <= '0;
            end else if (state_reg == hvn_pkg::B_OUT && out_free) begin
                slot_reg <= slot_reg + 2'd1;
            end
            if (state_reg == hvn_pkg::B_SETUP) begin
                bit_reg <= hvn_pkg::BIT_W'(hvn_pkg::F_W - 1);
            end else if (state_reg == hvn_pkg::B_ITER) begin
                bit_reg <= bit_reg - hvn_pkg::BIT_W'(1);
            end
            if (state_reg == hvn_pkg::B_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hvn_pkg::B_IDLE:  if (!q_stat.empty) state_next = hvn_pkg::B_SETUP;
            hvn_pkg::B_SETUP: state_next = hvn_pkg::B_ITER;
            hvn_pkg::B_ITER:  if (bit_reg == '0) state_next = hvn_pkg::B_OUT;
            hvn_pkg::B_OUT: begin
                if (out_free) begin
                    state_next = (slot_reg == job_reg.n - 2'd1) ? hvn_pkg::B_IDLE
                                                                : hvn_pkg::B_SETUP;
                end
            end
            default: state_next = hvn_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        q_pop = 1'b0;
        unique case (state_reg)
            hvn_pkg::B_IDLE: q_pop = !q_stat.empty;
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ test/tb_top.sv @@
// testbench for heightmap_vertex_normals_unit: streams height frames, predicts every
// vertex normal in a scoreboard class and checks each output word field by field
// depends on hvn_pkg and the heightmap_vertex_normals_unit rtl
`timescale 1ns / 100ps
module tb_top;

    localparam int LINE_MAX    = 1024;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 120;

    typedef struct {
        logic [15:0] nx;
        logic [14:0] ny;
        logic [15:0] nz;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        last;
        logic        fend;
    } normal_t;

    class vertex_normal_model;
        byte unsigned  cur_line[LINE_MAX];
        byte unsigned  prev_line[LINE_MAX];
        byte unsigned  older_line[LINE_MAX];
        int unsigned   col_cnt;
        int unsigned   row_cnt;
        logic [10:0]   width_reg;
        logic [10:0]   height_reg;
        normal_t       pending_normals[$];
        int            errors;
        int            checked;

        function new();
            col_cnt = 0;
            row_cnt = 0;
            width_reg = 11'd256;
            height_reg = 11'd256;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [hvn_pkg::CFG_IDX_W-1:0] idx, logic [10:0] val);
            if (idx == hvn_pkg::REG_GRID_WIDTH) width_reg = val;
            else if (idx == hvn_pkg::REG_GRID_HEIGHT) height_reg = val;
        endfunction

        function int clamp_size(logic [10:0] v);
            if (v < 2) return 2;
            if (v > LINE_MAX) return LINE_MAX;
            return int'(v);
        endfunction

        function int height_at(int rel, int col);
            if (col < 0 || col >= LINE_MAX) return 0;
            if (rel == 0) return cur_line[col];
            if (rel == 1) return prev_line[col];
            if (rel == 2) return older_line[col];
            return 0;
        endfunction

        // rounded 32768*|v|/sqrt(len2), saturated
        function logic [14:0] unit_mag(int v, longint unsigned len2);
            longint unsigned m, num, lo, hi, mid, t;
            m = (v < 0) ? longint'(-v) : longint'(v);
            num = (m * m) << 30;
            lo = 0;
            hi = 32768;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid * len2 <= num) lo = mid;
                else hi = mid - 1;
            end
            t = 2 * lo + 1;
            if (t * t * len2 <= (num << 2)) lo++;
            if (lo > 32767) lo = 32767;
            return lo[14:0];
        endfunction

        function logic [15:0] signed_comp(int v, longint unsigned len2);
            logic [15:0] q;
            q = {1'b0, unit_mag(v, len2)};
            return (v < 0) ? 16'(17'h10000 - q) : q;
        endfunction

        function normal_t vertex_normal(int i, int j, int r, int w, int h, bit fe);
            int sx, sy, sz, di, dj, a, b, d;
            longint unsigned len2;
            normal_t n;
            sx = 0;
            sy = 0;
            sz = 0;
            for (dj = j - 1; dj <= j; dj++)
                for (di = i - 1; di <= i; di++)
                    if (di >= 0 && dj >= 0 && di < w - 1 && dj < h - 1) begin
                        a = height_at(r - dj, di);
                        b = height_at(r - dj, di + 1);
                        d = height_at(r - dj - 1, di);
                        sx += a - b;
                        sy += hvn_pkg::FACE_UP;
                        sz += a - d;
                    end
            len2 = longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz);
            n.nx = signed_comp(sx, len2);
            n.ny = unit_mag(sy, len2);
            n.nz = signed_comp(sz, len2);
            n.col = i[9:0];
            n.row = j[9:0];
            n.last = 1'b0;
            n.fend = fe;
            return n;
        endfunction

        function void note_height(logic [7:0] hv);
            int w, h, c, r;
            normal_t batch[$];
            w = clamp_size(width_reg);
            h = clamp_size(height_reg);
            c = (col_cnt > w - 1) ? w - 1 : int'(col_cnt);
            r = (row_cnt > h - 1) ? h - 1 : int'(row_cnt);
            cur_line[c] = hv;
            if (r >= 1) batch.push_back(vertex_normal(c, r - 1, r, w, h, 0));
            if (r == h - 1) begin
                if (c >= 1) batch.push_back(vertex_normal(c - 1, r, r, w, h, 0));
                if (c == w - 1) batch.push_back(vertex_normal(c, r, r, w, h, 1));
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k]) pending_normals.push_back(batch[k]);
            if (c == w - 1) begin
                older_line = prev_line;
                prev_line = cur_line;
                col_cnt = 0;
                row_cnt = (r == h - 1) ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
                row_cnt = r;
            end
        endfunction

        function void check_normal(logic [hvn_pkg::TDATA_W-1:0] word, logic lst, logic usr);
            normal_t e;
            checked++;
            if (pending_normals.size() == 0) begin
                $display("%0t: unexpected word %h", $time, word);
                errors++;
                return;
            end
            e = pending_normals.pop_front();
            if (word[15:0] !== e.nx) begin
                $display("%0t: normal_x exp %h got %h", $time, e.nx, word[15:0]);
                errors++;
            end
            if (word[30:16] !== e.ny) begin
                $display("%0t: normal_y exp %h got %h", $time, e.ny, word[30:16]);
                errors++;
            end
            if (word[46:31] !== e.nz) begin
                $display("%0t: normal_z exp %h got %h", $time, e.nz, word[46:31]);
                errors++;
            end
            if (word[56:47] !== e.col) begin
                $display("%0t: vertex_col exp %0d got %0d", $time, e.col, word[56:47]);
                errors++;
            end
            if (word[66:57] !== e.row) begin
                $display("%0t: vertex_row exp %0d got %0d", $time, e.row, word[66:57]);
                errors++;
            end
            if (lst !== e.last) begin
                $display("%0t: last_of_run exp %b got %b", $time, e.last, lst);
                errors++;
            end
            if (usr !== e.fend) begin
                $display("%0t: frame_end exp %b got %b", $time, e.fend, usr);
                errors++;
            end
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [7:0]                       s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [hvn_pkg::TDATA_W-1:0]      m_tdata;
    logic                             m_tlast;
    logic                             m_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [hvn_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [hvn_pkg::CFG_DATA_W-1:0]   cfg_data;

    vertex_normal_model model;
    int sent_heights;
    int frames_done;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int holds;
    int cycles;
    int last_h;

    heightmap_vertex_normals_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // result side: check accepted words, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            model.check_normal(m_tdata, m_tlast, m_tuser);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [hvn_pkg::CFG_IDX_W-1:0] idx, logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        model.write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_height(logic [7:0] hv);
        if (sent_heights < 150) begin
            send_idle_pct = 17;
            recv_idle_pct = 49;
        end else if (sent_heights < 300) begin
            send_idle_pct = 49;
            recv_idle_pct = 17;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= hv;
        do @(posedge aclk); while (!s_tready);
        model.note_height(hv);
        sent_heights++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (model.pending_normals.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_height(int style);
        int v;
        case (style)
            0: v = $urandom_range(255);
            1: begin
                v = last_h + $urandom_range(8) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            2: v = $urandom_range(1) ? 255 : 0;
            default: v = last_h;
        endcase
        last_h = v;
        return v[7:0];
    endfunction

    task automatic run_frames(logic [10:0] wr, logic [10:0] hr, int count, int style);
        int w, h, k;
        write_reg(hvn_pkg::REG_GRID_WIDTH, wr);
        write_reg(hvn_pkg::REG_GRID_HEIGHT, hr);
        w = model.clamp_size(wr);
        h = model.clamp_size(hr);
        repeat (count) begin
            for (k = 0; k < w * h; k++) send_height(pick_height(style));
            frames_done++;
        end
        wait_idle();
    endtask

    initial begin
        int st;
        model = new();
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sent_heights = 0;
        frames_done = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 0;
        holds = 0;
        cycles = 0;
        last_h = 128;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // directed: clamped tiny grid with extreme heights, flat grid, 3x3 mix
        write_reg(hvn_pkg::REG_GRID_WIDTH, 11'd0);
        write_reg(hvn_pkg::REG_GRID_HEIGHT, 11'd1);
        send_height(8'd0);
        send_height(8'd255);
        send_height(8'd255);
        send_height(8'd0);
        wait_idle();
        run_frames(11'd1, 11'd0, 1, 3);
        write_reg(hvn_pkg::REG_GRID_WIDTH, 11'd3);
        write_reg(hvn_pkg::REG_GRID_HEIGHT, 11'd3);
        send_height(8'd255);
        send_height(8'd0);
        send_height(8'd255);
        send_height(8'd0);
        send_height(8'd255);
        send_height(8'd0);
        send_height(8'd255);
        send_height(8'd0);
        send_height(8'd255);
        wait_idle();

        // random grids of small size
        while (sent_heights < 420) begin
            st = $urandom_range(99);
            st = (st < 45) ? 0 : (st < 75) ? 1 : (st < 92) ? 2 : 3;
            if (sent_heights >= 200 && (holds == 0 || frames_done % 7 == 0)) begin
                hold_left = 400;
                holds++;
            end
            run_frames(11'($urandom_range(2, 10)), 11'($urandom_range(2, 7)),
                       $urandom_range(1, 2), st);
        end

        if (model.pending_normals.size() != 0) model.errors++;
        $display("covered %0d height samples in %0d frames, %0d normals checked",
                 sent_heights, frames_done, model.checked);
        $display("grids from clamped 2x2 up to 10 columns by 7 rows, %0d long output stalls",
                 holds);
        if (model.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
